// File: design/gss_pkg.sv
// ----------------------------------------------------------------------------
// gss_pkg
// Shared types and constants for the gear shift sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package gss_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int TIME_W    = 16;
    localparam int GEAR_W    = 4;
    localparam int LEVEL_W   = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UP_NEUTRAL_TO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_ACT_DELAY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_FINISH_TO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DN_ACT_DELAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DN_FINISH_TO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OL_UP_CUT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OL_DN_CLUTCH  = 3'd6;

    localparam logic [TIME_W-1:0] TIME_SAT = 16'hFFFF;

    localparam logic [LEVEL_W-1:0] LEVEL_NONE = 8'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_IDLE = 8'd127;
    localparam logic [LEVEL_W-1:0] LEVEL_CUT  = 8'd255;

    localparam logic [GEAR_W-1:0] GEAR_NEUTRAL = 4'd0;
    localparam logic [GEAR_W-1:0] GEAR_FIRST   = 4'd1;
    localparam logic [GEAR_W-1:0] GEAR_TOP     = 4'd4;
    localparam logic [GEAR_W-1:0] GEAR_MAX_UP  = 4'd5;

    typedef struct packed {
        logic [TIME_W-1:0] up_neutral_to;
        logic [TIME_W-1:0] up_act_delay;
        logic [TIME_W-1:0] up_finish_to;
        logic [TIME_W-1:0] dn_act_delay;
        logic [TIME_W-1:0] dn_finish_to;
        logic [TIME_W-1:0] ol_up_cut;
        logic [TIME_W-1:0] ol_dn_clutch;
        logic [TIME_W-1:0] ol_up_total;   // saturated delay + cut time
        logic [TIME_W-1:0] ol_dn_total;   // saturated delay + clutch time
    } t_cfg;

endpackage

`default_nettype wire

// File: design/gss_cfg_regs.sv
// ----------------------------------------------------------------------------
// gss_cfg_regs
// Configuration register file with write decode and open-loop time totals.
// ----------------------------------------------------------------------------
`default_nettype none

module gss_cfg_regs
    import gss_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_wr_index,
    input  wire logic [TIME_W-1:0]    i_wr_data,
    output t_cfg                      o_cfg
);

    logic [TIME_W-1:0] r_up_neutral_to, r_up_act_delay, r_up_finish_to;
    logic [TIME_W-1:0] r_dn_act_delay, r_dn_finish_to, r_ol_up_cut, r_ol_dn_clutch;
    logic [TIME_W:0]   up_sum, dn_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_neutral_to <= 16'd300;
            r_up_act_delay  <= 16'd20;
            r_up_finish_to  <= 16'd100;
            r_dn_act_delay  <= 16'd20;
            r_dn_finish_to  <= 16'd150;
            r_ol_up_cut     <= 16'd80;
            r_ol_dn_clutch  <= 16'd100;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_UP_NEUTRAL_TO: r_up_neutral_to <= i_wr_data;
                CFG_UP_ACT_DELAY:  r_up_act_delay  <= i_wr_data;
                CFG_UP_FINISH_TO:  r_up_finish_to  <= i_wr_data;
                CFG_DN_ACT_DELAY:  r_dn_act_delay  <= i_wr_data;
                CFG_DN_FINISH_TO:  r_dn_finish_to  <= i_wr_data;
                CFG_OL_UP_CUT:     r_ol_up_cut     <= i_wr_data;
                CFG_OL_DN_CLUTCH:  r_ol_dn_clutch  <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign up_sum = {1'b0, r_up_act_delay} + {1'b0, r_ol_up_cut};
    assign dn_sum = {1'b0, r_dn_act_delay} + {1'b0, r_ol_dn_clutch};

    always_comb begin
        o_cfg.up_neutral_to = r_up_neutral_to;
        o_cfg.up_act_delay  = r_up_act_delay;
        o_cfg.up_finish_to  = r_up_finish_to;
        o_cfg.dn_act_delay  = r_dn_act_delay;
        o_cfg.dn_finish_to  = r_dn_finish_to;
        o_cfg.ol_up_cut     = r_ol_up_cut;
        o_cfg.ol_dn_clutch  = r_ol_dn_clutch;
        o_cfg.ol_up_total   = up_sum[TIME_W] ? TIME_SAT : up_sum[TIME_W-1:0];
        o_cfg.ol_dn_total   = dn_sum[TIME_W] ? TIME_SAT : dn_sum[TIME_W-1:0];
    end

endmodule

`default_nettype wire

// File: design/gear_shift_sequencer.sv
// ----------------------------------------------------------------------------
// gear_shift_sequencer
// Gearbox shift sequencer stepped by one 1 ms tick per input transfer.
// ----------------------------------------------------------------------------
// Each input transfer is one millisecond tick carrying the sensed gear and the
// shift request bits; each tick yields exactly one output transfer with the
// actuator levels, cut level, busy flag and, on the tick a shift ends, the
// shift time. The sequence state update is a single short combinational step
// from the state registers into the state and output registers, so the block
// takes one tick per clock cycle when not stalled, with output valid in the
// cycle after the input transfer. The output register stalls only the input
// side when the downstream holds tready low with a result already waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module gear_shift_sequencer
    import gss_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [TIME_W-1:0]    i_cfg_data,
    // tick input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,  // sensed_gear[3:0], want_up[4],
                                                     // want_down[5], zero pad [7:6]
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [31:0]               m_axis_tdata,  // gear_up_drive[0],
                                                     // gear_down_drive[1], cut_drive[2],
                                                     // clutch_drive[3], cut_level[11:4],
                                                     // busy_res[12], time_valid[13],
                                                     // shift_time[29:14], zero pad [31:30]
    output logic                      m_axis_tuser   // time_is_down[0]
);

    localparam logic [3:0] PH_IDLE         = 4'd0;
    localparam logic [3:0] PH_UP_NEUTRAL   = 4'd1;
    localparam logic [3:0] PH_UP_CUT       = 4'd2;
    localparam logic [3:0] PH_UP_FINISH    = 4'd3;
    localparam logic [3:0] PH_DN_NEUTRAL   = 4'd4;
    localparam logic [3:0] PH_DN_REVMATCH  = 4'd5;
    localparam logic [3:0] PH_DN_FINISH    = 4'd6;
    localparam logic [3:0] PH_OL_UP_CUT    = 4'd7;
    localparam logic [3:0] PH_OL_UP_FINISH = 4'd8;
    localparam logic [3:0] PH_OL_DN_CLUTCH = 4'd9;
    localparam logic [3:0] PH_OL_DN_FINISH = 4'd10;

    t_cfg cfg;

    gss_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign o_cfg_ready = 1'b1;

    // sequence state
    logic [3:0]         r_phase,      n_phase;
    logic [GEAR_W-1:0]  r_start_gear, n_start_gear;
    logic [TIME_W-1:0]  r_phase_ms,   n_phase_ms;
    logic [TIME_W-1:0]  r_shift_ms,   n_shift_ms;
    logic               r_up,  n_up;
    logic               r_dn,  n_dn;
    logic               r_cut, n_cut;
    logic               r_clu, n_clu;
    logic [LEVEL_W-1:0] r_level, n_level;
    // result register
    logic               r_out_valid;
    logic [31:0]        r_out_data, n_out_data;
    logic               r_out_user, n_out_user;

    logic [GEAR_W-1:0]  gear;
    logic               want_up, want_dn;
    logic               t_valid, t_down;
    logic [TIME_W-1:0]  t_time;
    logic [TIME_W-1:0]  ph_inc, sh_inc;
    logic               take;

    assign gear    = s_axis_tdata[3:0];
    assign want_up = s_axis_tdata[4];
    assign want_dn = s_axis_tdata[5];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;

    assign ph_inc = (r_phase_ms == TIME_SAT) ? TIME_SAT : r_phase_ms + 16'd1;
    assign sh_inc = (r_shift_ms == TIME_SAT) ? TIME_SAT : r_shift_ms + 16'd1;

    always_comb begin
        n_phase      = r_phase;
        n_start_gear = r_start_gear;
        n_phase_ms   = r_phase_ms;
        n_shift_ms   = r_shift_ms;
        n_up         = r_up;
        n_dn         = r_dn;
        n_cut        = r_cut;
        n_clu        = r_clu;
        n_level      = r_level;
        t_valid      = 1'b0;
        t_down       = 1'b0;
        t_time       = '0;

        if (r_phase == PH_IDLE) begin
            if (want_up) begin
                n_start_gear = gear;
                n_phase_ms   = '0;
                n_shift_ms   = '0;
                if (gear > GEAR_MAX_UP) begin
                    n_up    = 1'b1;
                    n_phase = PH_OL_UP_CUT;
                end else if (gear != GEAR_TOP) begin
                    n_up    = 1'b1;
                    n_phase = (gear == GEAR_NEUTRAL) ? PH_UP_NEUTRAL : PH_UP_CUT;
                end
            end else if (want_dn) begin
                n_start_gear = gear;
                n_phase_ms   = '0;
                n_shift_ms   = '0;
                if (gear > GEAR_TOP) begin
                    n_dn    = 1'b1;
                    n_phase = PH_OL_DN_CLUTCH;
                end else if (gear != GEAR_NEUTRAL) begin
                    n_dn    = 1'b1;
                    n_phase = (gear == GEAR_FIRST) ? PH_DN_NEUTRAL : PH_DN_REVMATCH;
                end
            end
        end else begin
            n_phase_ms = ph_inc;
            n_shift_ms = sh_inc;
            unique case (r_phase)
                PH_UP_NEUTRAL: begin
                    if (gear == GEAR_FIRST || ph_inc > cfg.up_neutral_to) begin
                        n_up    = 1'b0;
                        t_valid = 1'b1;
                        t_time  = sh_inc;
                        n_phase = PH_IDLE;
                    end
                end
                PH_UP_CUT: begin
                    if (ph_inc > cfg.up_act_delay) begin
                        n_cut      = 1'b1;
                        n_phase_ms = '0;
                        n_level    = LEVEL_CUT;
                        n_phase    = PH_UP_FINISH;
                    end
                end
                PH_UP_FINISH: begin
                    // start gear is 1, 2, 3 or 5 here, so the next gear fits in five bits
                    if ({1'b0, gear} == {1'b0, r_start_gear} + 5'd1 ||
                        ph_inc > cfg.up_finish_to) begin
                        t_valid = 1'b1;
                        t_time  = sh_inc;
                        n_cut   = 1'b0;
                        n_up    = 1'b0;
                        n_level = LEVEL_IDLE;
                        n_phase = PH_IDLE;
                    end
                end
                PH_DN_NEUTRAL, PH_DN_REVMATCH: begin
                    if (ph_inc > cfg.dn_act_delay) begin
                        n_clu      = 1'b1;
                        n_phase_ms = '0;
                        if (r_phase == PH_DN_REVMATCH) begin
                            n_level = LEVEL_NONE;
                        end
                        n_phase = PH_DN_FINISH;
                    end
                end
                PH_DN_FINISH: begin
                    if ((r_start_gear != GEAR_NEUTRAL && gear == r_start_gear - 4'd1) ||
                        ph_inc > cfg.dn_finish_to) begin
                        t_valid = 1'b1;
                        t_down  = 1'b1;
                        t_time  = sh_inc;
                        n_clu   = 1'b0;
                        n_dn    = 1'b0;
                        n_level = LEVEL_IDLE;
                        n_phase = PH_IDLE;
                    end
                end
                PH_OL_UP_CUT: begin
                    if (ph_inc > cfg.up_act_delay) begin
                        n_cut      = 1'b1;
                        n_phase_ms = '0;
                        n_phase    = PH_OL_UP_FINISH;
                    end
                end
                PH_OL_UP_FINISH: begin
                    if (ph_inc > cfg.ol_up_cut) begin
                        n_cut   = 1'b0;
                        n_up    = 1'b0;
                        t_valid = 1'b1;
                        t_time  = cfg.ol_up_total;
                        n_phase = PH_IDLE;
                    end
                end
                PH_OL_DN_CLUTCH: begin
                    if (ph_inc > cfg.dn_act_delay) begin
                        n_clu      = 1'b1;
                        n_phase_ms = '0;
                        n_phase    = PH_OL_DN_FINISH;
                    end
                end
                PH_OL_DN_FINISH: begin
                    if (ph_inc > cfg.ol_dn_clutch) begin
                        n_clu   = 1'b0;
                        n_dn    = 1'b0;
                        t_valid = 1'b1;
                        t_down  = 1'b1;
                        t_time  = cfg.ol_dn_total;
                        n_phase = PH_IDLE;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end

        n_out_data = {2'b00, t_time, t_valid, (n_phase != PH_IDLE), n_level,
                      n_clu, n_cut, n_dn, n_up};
        n_out_user = t_down;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_start_gear <= GEAR_NEUTRAL;
            r_phase_ms   <= '0;
            r_shift_ms   <= '0;
            r_up         <= 1'b0;
            r_dn         <= 1'b0;
            r_cut        <= 1'b0;
            r_clu        <= 1'b0;
            r_level      <= LEVEL_IDLE;
            r_out_valid  <= 1'b0;
        end else begin
            if (take) begin
                r_phase      <= n_phase;
                r_start_gear <= n_start_gear;
                r_phase_ms   <= n_phase_ms;
                r_shift_ms   <= n_shift_ms;
                r_up         <= n_up;
                r_dn         <= n_dn;
                r_cut        <= n_cut;
                r_clu        <= n_clu;
                r_level      <= n_level;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire
